[hw/rtl/spq_pkg.sv]
// package for the stable priority event queue
// holds field widths, the command encoding and the cell control bundle
// used by spq_cell and stable_priority_event_queue_core
package spq_pkg;

  localparam int TIME_W              = 32;
  localparam int HANDLE_W            = 16;
  localparam int DEFAULT_QUEUE_DEPTH = 16;

  // command encoding on the input channel
  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_POP    = 1'b1
  } cmd_t;

  // per-cycle control broadcast to every cell of the chain
  typedef struct packed {
    logic                insert_en;
    logic                pop_en;
    logic [TIME_W-1:0]   ev_time;
    logic [HANDLE_W-1:0] ev_handle;
  } cell_ctrl_t;

endpackage

[hw/rtl/stable_priority_event_queue_core.sv]
// Sorted event queue built as a chain of QUEUE_DEPTH compare-and-shift cells.
// Every accepted transaction (insert or pop) is finished in the cycle it is
// accepted and its result appears on the output register in the next cycle, so
// the block takes one transaction per clock while out_ready holds: the rate is set
// by the compare and neighbor shift that all cells do in parallel. A new
// transaction is accepted whenever the output register is empty or is being
// taken in the same cycle. Ties keep arrival order; an insert into a full
// queue is dropped and flagged, and a pop on an empty queue returns no event.
// No clearing pass is needed after reset.
// depends on spq_pkg and spq_cell
module stable_priority_event_queue_core #(
  parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         command,
  input  logic [spq_pkg::TIME_W-1:0]   event_time,
  input  logic [spq_pkg::HANDLE_W-1:0] event_handle,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         pop_valid,
  output logic [spq_pkg::TIME_W-1:0]   popped_time,
  output logic [spq_pkg::HANDLE_W-1:0] popped_handle,
  output logic                         queue_empty,
  output logic                         insert_dropped
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic            in_fire;
  logic            is_pop;
  logic            full;
  logic            empty;
  spq_pkg::cell_ctrl_t ctrl;

  logic [QUEUE_DEPTH-1:0]       occupied;
  logic [QUEUE_DEPTH-1:0]       keep;
  logic [spq_pkg::TIME_W-1:0]   slot_time   [QUEUE_DEPTH];
  logic [spq_pkg::HANDLE_W-1:0] slot_handle [QUEUE_DEPTH];

  // handshake: accept while the result register is free or draining
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign is_pop   = (command == spq_pkg::CMD_POP);
  assign full     = (count == CW'(QUEUE_DEPTH));
  assign empty    = (count == '0);

  // control broadcast to the cells
  always_comb begin
    ctrl.insert_en = in_fire && !is_pop && !full;
    ctrl.pop_en    = in_fire && is_pop && !empty;
    ctrl.ev_time   = event_time;
    ctrl.ev_handle = event_handle;
  end

  // occupancy count
  always_comb begin
    count_next = count;
    if (ctrl.insert_en) begin
      count_next = count + 1'b1;
    end else if (ctrl.pop_en) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // chain of cells, head at index 0
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                         p_keep;
    logic [spq_pkg::TIME_W-1:0]   p_time;
    logic [spq_pkg::HANDLE_W-1:0] p_handle;
    logic [spq_pkg::TIME_W-1:0]   n_time;
    logic [spq_pkg::HANDLE_W-1:0] n_handle;

    assign occupied[i] = (count > CW'(i));

    if (i == 0) begin : g_head
      assign p_keep   = 1'b1;
      assign p_time   = '0;
      assign p_handle = '0;
    end else begin : g_body
      assign p_keep   = keep[i-1];
      assign p_time   = slot_time[i-1];
      assign p_handle = slot_handle[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign n_time   = '0;
      assign n_handle = '0;
    end else begin : g_inner
      assign n_time   = slot_time[i+1];
      assign n_handle = slot_handle[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (occupied[i]),
      .prev_keep   (p_keep),
      .prev_time   (p_time),
      .prev_handle (p_handle),
      .next_time   (n_time),
      .next_handle (n_handle),
      .keep        (keep[i]),
      .slot_time   (slot_time[i]),
      .slot_handle (slot_handle[i])
    );
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pop_valid      <= ctrl.pop_en;
      popped_time    <= ctrl.pop_en ? slot_time[0] : '0;
      popped_handle  <= ctrl.pop_en ? slot_handle[0] : '0;
      queue_empty    <= (count_next == '0);
      insert_dropped <= !is_pop && full;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("occupancy count above queue depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ctrl.insert_en |=> count == $past(count) + 1'b1)
    else $error("accepted insert did not grow the queue");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    ctrl.pop_en |=> count == $past(count) - 1'b1)
    else $error("accepted pop did not shrink the queue");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted transaction produced no result");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(pop_valid && insert_dropped) && !(pop_valid && queue_empty &&
      $past(count) != CW'(1) && $past(in_fire)))
    else $error("result flags inconsistent");

endmodule

[hw/rtl/spq_cell.sv]
// one slot of the sorted shift-register queue
// depends on spq_pkg for widths and the cell_ctrl_t control bundle
module spq_cell (
  input  logic                         clk,
  input  spq_pkg::cell_ctrl_t          ctrl,
  input  logic                         occupied,
  input  logic                         prev_keep,
  input  logic [spq_pkg::TIME_W-1:0]   prev_time,
  input  logic [spq_pkg::HANDLE_W-1:0] prev_handle,
  input  logic [spq_pkg::TIME_W-1:0]   next_time,
  input  logic [spq_pkg::HANDLE_W-1:0] next_handle,
  output logic                         keep,
  output logic [spq_pkg::TIME_W-1:0]   slot_time,
  output logic [spq_pkg::HANDLE_W-1:0] slot_handle
);

  // a stored entry stays put when it sorts at or before the new event
  assign keep = occupied && (slot_time <= ctrl.ev_time);

  // insert: hold, take the new event, or shift down; pop: shift up
  always_ff @(posedge clk) begin
    if (ctrl.insert_en) begin
      if (!keep) begin
        if (prev_keep) begin
          slot_time   <= ctrl.ev_time;
          slot_handle <= ctrl.ev_handle;
        end else begin
          slot_time   <= prev_time;
          slot_handle <= prev_handle;
        end
      end
    end else if (ctrl.pop_en) begin
      slot_time   <= next_time;
      slot_handle <= next_handle;
    end
  end

endmodule
